FILE: rtl/frustum_aabb_cull_unit_macros.svh
// Assertion helpers used by the cull unit top level.
`ifndef FRUSTUM_AABB_CULL_UNIT_MACROS_SVH
`define FRUSTUM_AABB_CULL_UNIT_MACROS_SVH

`ifndef NO_ASSERTIONS
`define FAC_ASSERT_IMP(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("%m: implication check failed");
`define FAC_ASSERT_NXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("%m: next-cycle check failed");
`else
`define FAC_ASSERT_IMP(label, clk, rst_n, ante, cons)
`define FAC_ASSERT_NXT(label, clk, rst_n, ante, cons)
`endif

`endif

FILE: rtl/fac_pkg.sv
package fac_pkg;

    localparam int NUM_ROWS   = 4;
    localparam int NUM_LANES  = 4;
    localparam int NUM_PLANES = 6;
    localparam int NUM_AXES   = 3;

    // Box coordinates carry this many fraction bits
    localparam int COORD_FRAC = 8;

    // 1.0 in a Q3.12 matrix lane
    localparam int MATRIX_ONE = 4096;

    localparam int DATA_WIDTH    = 64;
    localparam int ROW_IDX_WIDTH = 2;
    localparam int ADDR_WIDTH    = 5;
    localparam int ADDR_LSB      = 3;

    localparam logic [ROW_IDX_WIDTH-1:0] REG_ROW_0 = 2'd0;
    localparam logic [ROW_IDX_WIDTH-1:0] REG_ROW_1 = 2'd1;
    localparam logic [ROW_IDX_WIDTH-1:0] REG_ROW_2 = 2'd2;
    localparam logic [ROW_IDX_WIDTH-1:0] REG_ROW_3 = 2'd3;

    localparam int PL_LEFT   = 0;
    localparam int PL_RIGHT  = 1;
    localparam int PL_BOTTOM = 2;
    localparam int PL_TOP    = 3;
    localparam int PL_NEAR   = 4;
    localparam int PL_FAR    = 5;

    localparam int LANE_W = 3;

    typedef struct packed {
        logic en1;
        logic en2;
        logic en3;
    } pipe_ctrl_t;

endpackage

FILE: rtl/fac_cfg.sv
module fac_cfg #(
    parameter int MATRIX_WIDTH = 16
) (
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                psel,
    input  logic                                penable,
    input  logic                                pwrite,
    input  logic [fac_pkg::ADDR_WIDTH-1:0]      paddr,
    input  logic [fac_pkg::DATA_WIDTH-1:0]      pwdata,
    output logic [fac_pkg::DATA_WIDTH-1:0]      prdata,
    output logic                                pready,
    output logic signed [MATRIX_WIDTH:0]        plane_reg [fac_pkg::NUM_PLANES]
                                                          [fac_pkg::NUM_LANES]
);

    localparam int LW  = MATRIX_WIDTH;
    localparam int PCW = MATRIX_WIDTH + 1;

    logic [fac_pkg::DATA_WIDTH-1:0]    row_reg [fac_pkg::NUM_ROWS];
    logic [fac_pkg::ROW_IDX_WIDTH-1:0] row_idx;
    logic                              wr_en;
    logic signed [LW-1:0]              lane [fac_pkg::NUM_ROWS][fac_pkg::NUM_LANES];
    logic signed [PCW-1:0]             plane_next [fac_pkg::NUM_PLANES]
                                                  [fac_pkg::NUM_LANES];

    assign pready  = 1'b1;
    assign row_idx = paddr[fac_pkg::ADDR_WIDTH-1:fac_pkg::ADDR_LSB];
    assign wr_en   = psel & penable & pwrite & pready;
    assign prdata  = row_reg[row_idx];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int r = 0; r < fac_pkg::NUM_ROWS; r++)
            begin
                row_reg[r] <= fac_pkg::DATA_WIDTH'(fac_pkg::MATRIX_ONE) << (LW * r);
            end
        end
        else if (wr_en)
        begin
            row_reg[row_idx] <= pwdata;
        end
    end

    always_comb
    begin
        for (int r = 0; r < fac_pkg::NUM_ROWS; r++)
        begin
            for (int c = 0; c < fac_pkg::NUM_LANES; c++)
            begin
                lane[r][c] = row_reg[r][LW*c +: LW];
            end
        end
        for (int c = 0; c < fac_pkg::NUM_LANES; c++)
        begin
            plane_next[fac_pkg::PL_LEFT][c]   = PCW'(lane[3][c]) + PCW'(lane[0][c]);
            plane_next[fac_pkg::PL_RIGHT][c]  = PCW'(lane[3][c]) - PCW'(lane[0][c]);
            plane_next[fac_pkg::PL_BOTTOM][c] = PCW'(lane[3][c]) + PCW'(lane[1][c]);
            plane_next[fac_pkg::PL_TOP][c]    = PCW'(lane[3][c]) - PCW'(lane[1][c]);
            plane_next[fac_pkg::PL_NEAR][c]   = PCW'(lane[2][c]);
            plane_next[fac_pkg::PL_FAR][c]    = PCW'(lane[3][c]) - PCW'(lane[2][c]);
        end
    end

    // Planes are registered from the matrix rows, so they follow a write in the next cycle
    always_ff @(posedge clk)
    begin
        plane_reg <= plane_next;
    end

endmodule

FILE: rtl/fac_plane.sv
module fac_plane #(
    parameter int COORD_WIDTH  = 24,
    parameter int MATRIX_WIDTH = 16
) (
    input  logic                          clk,
    input  logic                          rst_n,
    input  fac_pkg::pipe_ctrl_t           ctrl,
    input  logic signed [MATRIX_WIDTH:0]  plane [fac_pkg::NUM_LANES],
    input  logic signed [COORD_WIDTH-1:0] lo [fac_pkg::NUM_AXES],
    input  logic signed [COORD_WIDTH-1:0] hi [fac_pkg::NUM_AXES],
    output logic                          neg_reg
);

    localparam int PCW = MATRIX_WIDTH + 1;
    localparam int PW  = PCW + COORD_WIDTH;
    localparam int SW  = PW + 1;

    logic signed [COORD_WIDTH-1:0] corner [fac_pkg::NUM_AXES];
    logic signed [PW-1:0]          prod_next [fac_pkg::NUM_AXES];
    logic signed [PW-1:0]          prod_reg  [fac_pkg::NUM_AXES];
    logic signed [PW-1:0]          w_next;
    logic signed [PW-1:0]          w_reg;
    logic signed [SW-1:0]          sum_a_next;
    logic signed [SW-1:0]          sum_b_next;
    logic signed [SW-1:0]          sum_a_reg;
    logic signed [SW-1:0]          sum_b_reg;
    logic signed [SW:0]            total;
    logic                          neg_next;

    // Take the corner farthest along the normal: max where the component is >= 0
    always_comb
    begin
        for (int c = 0; c < fac_pkg::NUM_AXES; c++)
        begin
            corner[c]    = plane[c][PCW-1] ? lo[c] : hi[c];
            prod_next[c] = PW'(plane[c]) * PW'(corner[c]);
        end
        w_next = PW'(plane[fac_pkg::LANE_W]) <<< fac_pkg::COORD_FRAC;
    end

    assign sum_a_next = SW'(prod_reg[0]) + SW'(prod_reg[1]);
    assign sum_b_next = SW'(prod_reg[2]) + SW'(w_reg);
    assign total      = (SW+1)'(sum_a_reg) + (SW+1)'(sum_b_reg);
    assign neg_next   = total[SW];

    always_ff @(posedge clk)
    begin
        if (ctrl.en1)
        begin
            prod_reg <= prod_next;
            w_reg    <= w_next;
        end
        if (ctrl.en2)
        begin
            sum_a_reg <= sum_a_next;
            sum_b_reg <= sum_b_next;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            neg_reg <= 1'b0;
        end
        else if (ctrl.en3)
        begin
            neg_reg <= neg_next;
        end
    end

endmodule

FILE: rtl/frustum_aabb_cull_unit.sv
// Frustum cull unit: tests world-space boxes against the six clip planes
// of a view-projection matrix (positive-vertex test).
// Configuration: APB-style port, four 64-bit matrix rows at 0x00, 0x08,
// 0x10 and 0x18, each holding four signed lanes (column 0 in the low lane).
// pready is always high; reads return the row. Reset loads the identity.
// Box channel: item_valid/item_ready with min_x..max_z, one transaction
// per box. Result channel: result_valid/result_ready with visible.
// A box passes through four register stages in order: input register,
// corner select and multiply, partial sums, final sum and sign; its result
// is valid while it sits in the last stage. One box per cycle is sustained
// while result_ready is high; each plane has one multiplier per axis. Each
// stage holds while the stage after it is full and stalled, so when
// result_ready is low the bubbles fill up and item_ready drops only once
// all four stages hold a transaction. Reset empties the pipeline. A matrix
// write takes effect for boxes accepted from the cycle after the write.
`include "frustum_aabb_cull_unit_macros.svh"

module frustum_aabb_cull_unit #(
    parameter int COORD_WIDTH  = 24,
    parameter int MATRIX_WIDTH = 16
) (
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                psel,
    input  logic                                penable,
    input  logic                                pwrite,
    input  logic [fac_pkg::ADDR_WIDTH-1:0]      paddr,
    input  logic [fac_pkg::DATA_WIDTH-1:0]      pwdata,
    output logic [fac_pkg::DATA_WIDTH-1:0]      prdata,
    output logic                                pready,
    input  logic                                item_valid,
    output logic                                item_ready,
    input  logic signed [COORD_WIDTH-1:0]       min_x,
    input  logic signed [COORD_WIDTH-1:0]       min_y,
    input  logic signed [COORD_WIDTH-1:0]       min_z,
    input  logic signed [COORD_WIDTH-1:0]       max_x,
    input  logic signed [COORD_WIDTH-1:0]       max_y,
    input  logic signed [COORD_WIDTH-1:0]       max_z,
    output logic                                result_valid,
    input  logic                                result_ready,
    output logic                                visible
);

    logic signed [MATRIX_WIDTH:0]   plane [fac_pkg::NUM_PLANES][fac_pkg::NUM_LANES];
    logic signed [COORD_WIDTH-1:0]  lo_reg [fac_pkg::NUM_AXES];
    logic signed [COORD_WIDTH-1:0]  hi_reg [fac_pkg::NUM_AXES];
    logic                           v0_reg;
    logic                           v1_reg;
    logic                           v2_reg;
    logic                           v3_reg;
    logic                           en0;
    fac_pkg::pipe_ctrl_t            ctrl;
    logic [fac_pkg::NUM_PLANES-1:0] neg;

    fac_cfg #(
        .MATRIX_WIDTH (MATRIX_WIDTH)
    ) u_cfg (
        .clk       (clk),
        .rst_n     (rst_n),
        .psel      (psel),
        .penable   (penable),
        .pwrite    (pwrite),
        .paddr     (paddr),
        .pwdata    (pwdata),
        .prdata    (prdata),
        .pready    (pready),
        .plane_reg (plane)
    );

    // A stage advances when the next one is empty or advancing itself
    assign ctrl.en3   = !v3_reg || result_ready;
    assign ctrl.en2   = !v2_reg || ctrl.en3;
    assign ctrl.en1   = !v1_reg || ctrl.en2;
    assign en0        = !v0_reg || ctrl.en1;
    assign item_ready = en0;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v0_reg <= 1'b0;
            v1_reg <= 1'b0;
            v2_reg <= 1'b0;
            v3_reg <= 1'b0;
        end
        else
        begin
            if (en0)
            begin
                v0_reg <= item_valid;
            end
            if (ctrl.en1)
            begin
                v1_reg <= v0_reg;
            end
            if (ctrl.en2)
            begin
                v2_reg <= v1_reg;
            end
            if (ctrl.en3)
            begin
                v3_reg <= v2_reg;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (en0 && item_valid)
        begin
            lo_reg[0] <= min_x;
            lo_reg[1] <= min_y;
            lo_reg[2] <= min_z;
            hi_reg[0] <= max_x;
            hi_reg[1] <= max_y;
            hi_reg[2] <= max_z;
        end
    end

    for (genvar p = 0; p < fac_pkg::NUM_PLANES; p++)
    begin : g_plane
        fac_plane #(
            .COORD_WIDTH  (COORD_WIDTH),
            .MATRIX_WIDTH (MATRIX_WIDTH)
        ) u_plane (
            .clk     (clk),
            .rst_n   (rst_n),
            .ctrl    (ctrl),
            .plane   (plane[p]),
            .lo      (lo_reg),
            .hi      (hi_reg),
            .neg_reg (neg[p])
        );
    end

    assign result_valid = v3_reg;
    assign visible      = ~|neg;

    `FAC_ASSERT_IMP(a_stall_only_when_full, clk, rst_n, !item_ready,
                    v0_reg && v1_reg && v2_reg && v3_reg && !result_ready)
    `FAC_ASSERT_NXT(a_accept_fills_s0, clk, rst_n, item_valid && item_ready, v0_reg)
    `FAC_ASSERT_NXT(a_s0_moves_to_s1, clk, rst_n, v0_reg && ctrl.en1, v1_reg)
    `FAC_ASSERT_NXT(a_s2_drains_into_empty_s3, clk, rst_n, v2_reg && !v3_reg, v3_reg)

endmodule

FILE: tb/sv/testbench.sv
module testbench;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int COORD_W          = 24;
    localparam int MATRIX_W         = 16;
    localparam int NUM_PHASES       = 15;
    localparam int RANDOM_PER_PHASE = 90;
    localparam int PIPE_LATENCY     = 4;
    localparam int DRAIN_CYCLES     = 3 * PIPE_LATENCY;
    localparam int MAX_REPORTED     = 10;
    localparam int LONG_HOLD_CYCLES = 150;

    localparam logic [fac_pkg::ROW_IDX_WIDTH-1:0] ROW_REGS [fac_pkg::NUM_ROWS] = '{
        fac_pkg::REG_ROW_0, fac_pkg::REG_ROW_1, fac_pkg::REG_ROW_2, fac_pkg::REG_ROW_3
    };

    typedef logic signed [COORD_W-1:0] coord_t;

    typedef struct packed {
        coord_t min_x;
        coord_t min_y;
        coord_t min_z;
        coord_t max_x;
        coord_t max_y;
        coord_t max_z;
    } box_t;

    logic                             clk;
    logic                             rst_n        = 1'b0;
    logic                             psel         = 1'b0;
    logic                             penable      = 1'b0;
    logic                             pwrite       = 1'b0;
    logic [fac_pkg::ADDR_WIDTH-1:0]   paddr        = '0;
    logic [fac_pkg::DATA_WIDTH-1:0]   pwdata       = '0;
    logic [fac_pkg::DATA_WIDTH-1:0]   prdata;
    logic                             pready;
    logic                             item_valid   = 1'b0;
    logic                             item_ready;
    coord_t                           min_x        = '0;
    coord_t                           min_y        = '0;
    coord_t                           min_z        = '0;
    coord_t                           max_x        = '0;
    coord_t                           max_y        = '0;
    coord_t                           max_z        = '0;
    logic                             result_valid;
    logic                             result_ready = 1'b0;
    logic                             visible;

    logic [fac_pkg::DATA_WIDTH-1:0]   matrix_rows [fac_pkg::NUM_ROWS];
    box_t                             pending_boxes [$];
    logic                             expected_visible [$];
    box_t                             offered_box;
    int                               sender_idle_max   = 0;
    int                               receiver_idle_max = 0;
    int                               sender_wait       = 0;
    int                               receiver_wait     = 0;
    int                               long_hold         = 0;
    int                               results_seen      = 0;
    int                               failures          = 0;

    frustum_aabb_cull_unit #(
        .COORD_WIDTH  (COORD_W),
        .MATRIX_WIDTH (MATRIX_W)
    ) i_dut (
        .clk          (clk),
        .rst_n        (rst_n),
        .psel         (psel),
        .penable      (penable),
        .pwrite       (pwrite),
        .paddr        (paddr),
        .pwdata       (pwdata),
        .prdata       (prdata),
        .pready       (pready),
        .item_valid   (item_valid),
        .item_ready   (item_ready),
        .min_x        (min_x),
        .min_y        (min_y),
        .min_z        (min_z),
        .max_x        (max_x),
        .max_y        (max_y),
        .max_z        (max_z),
        .result_valid (result_valid),
        .result_ready (result_ready),
        .visible      (visible)
    );

    initial
    begin
        clk = 1'b0;
        forever #1 clk = ~clk;
    end

    initial
    begin
        #2_000_000;
        $display("CHECK FAILED");
        $finish;
    end

    // Positive-vertex test of one box against the six planes of the current matrix
    function automatic logic box_visible(box_t b);
        longint lo [fac_pkg::NUM_AXES];
        longint hi [fac_pkg::NUM_AXES];
        longint r [fac_pkg::NUM_ROWS];
        longint n [fac_pkg::NUM_LANES];
        longint distance;
        logic   seen;
        lo[0] = longint'($signed(b.min_x));
        lo[1] = longint'($signed(b.min_y));
        lo[2] = longint'($signed(b.min_z));
        hi[0] = longint'($signed(b.max_x));
        hi[1] = longint'($signed(b.max_y));
        hi[2] = longint'($signed(b.max_z));
        seen = 1'b1;
        for (int p = 0; p < fac_pkg::NUM_PLANES; p++)
        begin
            for (int c = 0; c < fac_pkg::NUM_LANES; c++)
            begin
                for (int k = 0; k < fac_pkg::NUM_ROWS; k++)
                    r[k] = longint'($signed(matrix_rows[k][MATRIX_W*c +: MATRIX_W]));
                case (p)
                    fac_pkg::PL_LEFT:   n[c] = r[3] + r[0];
                    fac_pkg::PL_RIGHT:  n[c] = r[3] - r[0];
                    fac_pkg::PL_BOTTOM: n[c] = r[3] + r[1];
                    fac_pkg::PL_TOP:    n[c] = r[3] - r[1];
                    fac_pkg::PL_NEAR:   n[c] = r[2];
                    default:            n[c] = r[3] - r[2];
                endcase
            end
            // w carries no coordinate, so lift it to the coordinate fraction
            distance = n[3] * (longint'(1) << fac_pkg::COORD_FRAC);
            for (int a = 0; a < fac_pkg::NUM_AXES; a++)
                distance += n[a] * ((n[a] >= 0) ? hi[a] : lo[a]);
            if (distance < 0)
                seen = 1'b0;
        end
        return seen;
    endfunction

    function automatic box_t make_box(int x0, int y0, int z0, int x1, int y1, int z1);
        box_t b;
        b.min_x = coord_t'(x0);
        b.min_y = coord_t'(y0);
        b.min_z = coord_t'(z0);
        b.max_x = coord_t'(x1);
        b.max_y = coord_t'(y1);
        b.max_z = coord_t'(z1);
        return b;
    endfunction

    // Mostly ordered boxes near the unit frustum, plus full-range and unordered ones
    function automatic box_t random_box();
        coord_t v [6];
        coord_t t;
        int     kind;
        kind = $urandom_range(0, 9);
        for (int i = 0; i < 6; i++)
        begin
            if (kind < 6)
                v[i] = coord_t'($urandom_range(0, 1600)) - coord_t'(800);
            else
                v[i] = coord_t'($urandom());
        end
        if (kind != 5 && kind < 8)
        begin
            for (int a = 0; a < 3; a++)
            begin
                if (v[a] > v[a+3])
                begin
                    t      = v[a];
                    v[a]   = v[a+3];
                    v[a+3] = t;
                end
            end
        end
        return make_box(v[0], v[1], v[2], v[3], v[4], v[5]);
    endfunction

    function automatic logic [fac_pkg::DATA_WIDTH-1:0] phase_row(int ph, int r);
        logic [fac_pkg::DATA_WIDTH-1:0] row;
        row = '0;
        case (ph)
            1: row = {4{16'h8000}};
            2: row = {4{16'h7fff}};
            3: row = '0;
            4: row = '1;
            // zero normals everywhere, negative w in row 3 only
            5: if (r == 3) row[MATRIX_W*3 +: MATRIX_W] = 16'hf000;
            6:
            begin
                case (r)
                    0: row[MATRIX_W*0 +: MATRIX_W] = 16'h1800;
                    1: row[MATRIX_W*1 +: MATRIX_W] = 16'h2000;
                    2: row = {16'hff00, 16'h1100, 16'h0000, 16'h0000};
                    default: row[MATRIX_W*2 +: MATRIX_W] = 16'h1000;
                endcase
            end
            NUM_PHASES - 1: row = 64'(fac_pkg::MATRIX_ONE) << (MATRIX_W * r);
            default:
            begin
                if (ph % 2 == 1)
                    row = {$urandom(), $urandom()};
                else
                    for (int c = 0; c < fac_pkg::NUM_LANES; c++)
                        row[MATRIX_W*c +: MATRIX_W] = 16'($urandom_range(0, 16384) - 8192);
            end
        endcase
        return row;
    endfunction

    function automatic void note_failure(string what);
        if (failures < MAX_REPORTED)
            $display("%s", what);
        failures++;
    endfunction

    task automatic write_row(logic [fac_pkg::ROW_IDX_WIDTH-1:0] reg_idx,
                             logic [fac_pkg::DATA_WIDTH-1:0] value);
        @(posedge clk);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= {reg_idx, {fac_pkg::ADDR_LSB{1'b0}}};
        pwdata  <= value;
        @(posedge clk);
        penable <= 1'b1;
        do
            @(posedge clk);
        while (!pready);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        matrix_rows[reg_idx] = value;
    endtask

    task automatic drain();
        while (pending_boxes.size() != 0 || item_valid || expected_visible.size() != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);
    endtask

    // Sender: hold each box until accepted, then idle for its drawn gap
    always @(posedge clk)
    begin
        box_t nb;
        if (rst_n)
        begin
            if (item_valid && item_ready)
                expected_visible.push_back(box_visible(offered_box));
            if (!item_valid || item_ready)
            begin
                if (sender_wait > 0)
                begin
                    sender_wait <= sender_wait - 1;
                    item_valid  <= 1'b0;
                end
                else if (pending_boxes.size() > 0)
                begin
                    nb = pending_boxes.pop_front();
                    offered_box <= nb;
                    min_x       <= nb.min_x;
                    min_y       <= nb.min_y;
                    min_z       <= nb.min_z;
                    max_x       <= nb.max_x;
                    max_y       <= nb.max_y;
                    max_z       <= nb.max_z;
                    item_valid  <= 1'b1;
                    sender_wait <= $urandom_range(0, sender_idle_max);
                end
                else
                    item_valid <= 1'b0;
            end
        end
    end

    // Receiver: check each transaction, then stall for a drawn gap
    always @(posedge clk)
    begin
        int   gap;
        logic want;
        if (rst_n)
        begin
            if (result_valid && result_ready)
            begin
                results_seen++;
                if (expected_visible.size() == 0)
                    note_failure($sformatf("result %0d: visible=%0b with no box pending",
                                           results_seen, visible));
                else
                begin
                    want = expected_visible.pop_front();
                    if (visible !== want)
                        note_failure($sformatf("result %0d: visible expected %0b, got %0b",
                                               results_seen, want, visible));
                end
            end
            if (long_hold > 0)
            begin
                long_hold    <= long_hold - 1;
                result_ready <= (long_hold == 1);
            end
            else if (result_valid && result_ready)
            begin
                // hold off long enough to fill every stage and back up the input
                if (results_seen % 600 == 200)
                begin
                    long_hold    <= LONG_HOLD_CYCLES;
                    result_ready <= 1'b0;
                end
                else
                begin
                    gap = $urandom_range(0, receiver_idle_max);
                    receiver_wait <= gap;
                    result_ready  <= (gap == 0);
                end
            end
            else if (receiver_wait > 0)
            begin
                receiver_wait <= receiver_wait - 1;
                result_ready  <= (receiver_wait == 1);
            end
            else
                result_ready <= 1'b1;
        end
    end

    initial
    begin
        for (int r = 0; r < fac_pkg::NUM_ROWS; r++)
            matrix_rows[r] = 64'(fac_pkg::MATRIX_ONE) << (MATRIX_W * r);
        repeat (4) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);
        for (int ph = 0; ph < NUM_PHASES; ph++)
        begin
            if (ph > 0)
            begin
                drain();
                for (int r = 0; r < fac_pkg::NUM_ROWS; r++)
                    write_row(ROW_REGS[r], phase_row(ph, r));
                @(posedge clk);
            end
            sender_idle_max   = (ph % 3 == 0) ? 0 : ((ph % 3 == 1) ? 18 : 5);
            receiver_idle_max = (ph % 4 == 0) ? 0 : ((ph % 4 == 2) ? 3 : 18);
            if (ph == 0)
            begin
                // identity matrix: the frustum is the cube [-1,1] x [-1,1] x [0,1]
                pending_boxes.push_back(make_box(-128, -128, 0, 128, 128, 128));
                pending_boxes.push_back(make_box(300, -10, 10, 400, 10, 20));
                pending_boxes.push_back(make_box(256, 0, 0, 256, 0, 0));
                pending_boxes.push_back(make_box(257, 0, 0, 300, 0, 0));
                pending_boxes.push_back(make_box(-300, 0, 0, -257, 0, 0));
                pending_boxes.push_back(make_box(-300, 0, 0, -256, 0, 0));
                pending_boxes.push_back(make_box(0, 257, 0, 0, 300, 0));
                pending_boxes.push_back(make_box(0, -300, 0, 0, -257, 0));
                pending_boxes.push_back(make_box(0, 0, -10, 0, 0, -1));
                pending_boxes.push_back(make_box(0, 0, -10, 0, 0, 0));
                pending_boxes.push_back(make_box(0, 0, 256, 0, 0, 256));
                pending_boxes.push_back(make_box(0, 0, 257, 0, 0, 300));
                pending_boxes.push_back(make_box(-8388608, -8388608, -8388608,
                                                 8388607, 8388607, 8388607));
                pending_boxes.push_back(make_box(-8388608, -8388608, -8388608,
                                                 -8388608, -8388608, -8388608));
                pending_boxes.push_back(make_box(8388607, 8388607, 8388607,
                                                 8388607, 8388607, 8388607));
                // min above max: corners still follow the normal signs
                pending_boxes.push_back(make_box(8388607, 8388607, 8388607,
                                                 -8388608, -8388608, -8388608));
                pending_boxes.push_back(make_box(100, 100, 100, -100, -100, 50));
                pending_boxes.push_back(make_box(0, 0, 0, 0, 0, 0));
                pending_boxes.push_back(make_box(32'h555555, 32'haaaaaa, 32'h555555,
                                                 32'haaaaaa, 32'h555555, 32'haaaaaa));
                pending_boxes.push_back(make_box(32'haaaaaa, 32'h555555, 32'haaaaaa,
                                                 32'h555555, 32'haaaaaa, 32'h555555));
            end
            for (int k = 0; k < RANDOM_PER_PHASE; k++)
                pending_boxes.push_back(random_box());
        end
        drain();
        if (failures == 0)
            $display("CHECK OK");
        else
            $display("CHECK FAILED");
        $finish;
    end

endmodule
